@@ rtl/sidt_pkg.sv @@
// Package for the sorted insert-and-drain table.
// Holds default sizes and the result status codes; no dependencies.
package sidt_pkg;

  localparam int unsigned DefDepth       = 32;
  localparam int unsigned DefKeyBits     = 16;
  localparam int unsigned DefPayloadBits = 32;

  typedef enum logic [1:0] {
    ST_DRAINED  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

endpackage

@@ rtl/sidt_ram.sv @@
// Single-port-write, single-port-read record memory for the sorted table.
// Read data is registered; no package dependencies.
module sidt_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/sorted_insert_and_drain_table.sv @@
// Sorted insert-and-drain table: a record memory kept in ascending key order.
// An insert walks down from the top of the table, moving one record up per cycle
// through the single write port of the memory while the shared comparator checks
// the next record, until a stored key is equal or smaller or the bottom is reached.
// A drain emits one entry per cycle while the output is free, limited by the one
// memory read port. Input is taken only between items; a finished result sits in an
// output register so the next item may be accepted before it is taken. Ties keep
// arrival order. Memory contents need no clearing after reset.
module sorted_insert_and_drain_table #(
  parameter int unsigned DEPTH        = sidt_pkg::DefDepth,
  parameter int unsigned KEY_BITS     = sidt_pkg::DefKeyBits,
  parameter int unsigned PAYLOAD_BITS = sidt_pkg::DefPayloadBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic signed [KEY_BITS-1:0]     sort_key_i,
  input  logic        [PAYLOAD_BITS-1:0] payload_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [1:0]              status_o,
  output logic signed [KEY_BITS-1:0]     out_key_o,
  output logic        [PAYLOAD_BITS-1:0] out_payload_o,
  output logic                           last_o
);
  import sidt_pkg::*;

  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned WordW = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_CMP   = 5'b00100,
    S_PUT   = 5'b01000,
    S_DOUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            mode_q;
  logic signed [KEY_BITS-1:0]     key_q;
  logic        [PAYLOAD_BITS-1:0] pay_q;

  logic                           out_valid_q, out_valid_d;
  status_e                        status_q, status_d;
  logic signed [KEY_BITS-1:0]     out_key_q, out_key_d;
  logic        [PAYLOAD_BITS-1:0] out_pay_q, out_pay_d;
  logic                           last_q, last_d;

  logic            out_free, emit, in_xfer;
  logic            wr_en, rd_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  logic [WordW-1:0] wr_data, rd_data;
  logic signed [KEY_BITS-1:0]     rd_key;
  logic        [PAYLOAD_BITS-1:0] rd_pay;
  logic [CntW-1:0] cnt_m1;
  logic            key_less, is_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign rd_key   = rd_data[WordW-1:PAYLOAD_BITS];
  assign rd_pay   = rd_data[PAYLOAD_BITS-1:0];
  assign cnt_m1   = count_q - CntW'(1);
  // shared comparator: new key strictly below the record just read
  assign key_less = key_q < rd_key;
  assign is_last  = (CntW'(idx_q) + CntW'(1)) == count_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    emit      = 1'b0;
    status_d  = status_q;
    out_key_d = '0;
    out_pay_d = '0;
    last_d    = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = {key_q, pay_q};
    rd_en     = 1'b0;
    rd_addr   = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_START;
        end
      end
      S_START: begin
        if (!mode_q) begin
          if (count_q == CntW'(DEPTH)) begin
            if (out_free) begin
              emit     = 1'b1;
              status_d = ST_FULL;
              state_d  = S_IDLE;
            end
          end else if (count_q == '0) begin
            idx_d   = '0;
            state_d = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_m1[IdxW-1:0];
            idx_d   = cnt_m1[IdxW-1:0];
            state_d = S_CMP;
          end
        end else begin
          if (count_q == '0) begin
            if (out_free) begin
              emit     = 1'b1;
              status_d = ST_EMPTY;
              state_d  = S_IDLE;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            state_d = S_DOUT;
          end
        end
      end
      S_CMP: begin
        if (key_less) begin
          // move the larger record up one slot, then look further down
          wr_en   = 1'b1;
          wr_addr = idx_q + IdxW'(1);
          wr_data = rd_data;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q - IdxW'(1);
            idx_d   = idx_q - IdxW'(1);
          end
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          wr_en    = 1'b1;
          count_d  = count_q + CntW'(1);
          emit     = 1'b1;
          status_d = ST_ACCEPTED;
          state_d  = S_IDLE;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          emit      = 1'b1;
          status_d  = ST_DRAINED;
          out_key_d = rd_key;
          out_pay_d = rd_pay;
          last_d    = is_last;
          if (is_last) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q + IdxW'(1);
            idx_d   = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  sidt_ram #(
    .DEPTH(DEPTH),
    .WIDTH(WordW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q <= mode_i;
      key_q  <= sort_key_i;
      pay_q  <= payload_i;
    end
    if (emit) begin
      status_q  <= status_d;
      out_key_q <= out_key_d;
      out_pay_q <= out_pay_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = out_key_q;
  assign out_payload_o = out_pay_q;
  assign last_o        = last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above table depth");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result written over an untaken result");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && status_d == ST_ACCEPTED) |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted insert did not grow the table");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && status_d == ST_DRAINED && last_d) |=> (count_q == '0 && state_q == S_IDLE))
    else $error("final drained entry did not empty the table");
`endif

endmodule
